// File: sv/ypvr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ypvr_pkg;

  localparam int SINE_TABLE_ENTRIES  = 256;
  localparam int COORD_FRACTION_BITS = 12;

  localparam int ANGLE_W     = 24;
  localparam int SIN_W       = COORD_FRACTION_BITS + 2;
  localparam int IDX_W       = $clog2(SINE_TABLE_ENTRIES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0]        GAIN_RESET   = 16'd400;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 24'h400000;
  localparam logic [63:0]        PI_Q30       = 64'd3373259426;

  typedef struct packed {
    logic signed [11:0] cursor_dx;
    logic signed [11:0] cursor_dy;
  } ypvr_in_t;

  typedef struct packed {
    logic [2:0]         vector_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic               last;
  } ypvr_out_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        yaw;
    logic signed [ANGLE_W-1:0] pitch;
  } ypvr_angles_t;

  typedef logic signed [SIN_W-1:0] sine_tab_t [SINE_TABLE_ENTRIES];

  // sine of r/2^30 quarter turns, Taylor series in Q30, rounded to QF
  function automatic logic [63:0] quarter_sine(input logic [63:0] r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    int                 n;
    x    = (r * PI_Q30) >> 31;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        default: term = term / 156;
      endcase
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = 64'((sum + (64'sd1 <<< (29 - COORD_FRACTION_BITS))) >>> (30 - COORD_FRACTION_BITS));
    if (v > (64'd1 << COORD_FRACTION_BITS)) begin
      v = 64'd1 << COORD_FRACTION_BITS;
    end
    return v;
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] t;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] mag;
    int          k;
    for (k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      t = (64'(k) << 32) / SINE_TABLE_ENTRIES;
      q = (t >> 30) & 64'd3;
      r = t & 64'h3FFF_FFFF;
      if (q[0]) begin
        mag = quarter_sine((64'd1 << 30) - r);
      end else begin
        mag = quarter_sine(r);
      end
      tab[k] = q[1] ? SIN_W'(64'd0 - mag) : SIN_W'(mag);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

// File: sv/ypvr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ypvr_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire ypvr_pkg::ypvr_in_t      in_data,
  input  wire logic                    cfg_valid,
  input  wire logic [15:0]             cfg_data,
  output logic                         push_valid,
  input  wire logic                    push_ready,
  output ypvr_pkg::ypvr_angles_t       push_data
);
  import ypvr_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic signed [28:0] PITCH_MAX = 29'sh400000;
  localparam logic signed [28:0] PITCH_MIN = -29'sh400000;

  logic [1:0]                state_r, state_nxt;
  logic [15:0]               gain_r;
  logic signed [16:0]        gain_s;
  logic signed [11:0]        dx_r, dy_r;
  logic signed [28:0]        prod_x_r, prod_y_r;
  logic [ANGLE_W-1:0]        yaw_r, yaw_nxt;
  logic signed [ANGLE_W-1:0] pitch_r, pitch_nxt;
  logic signed [28:0]        pitch_sum;

  assign in_stall   = (state_r != F_IDLE);
  assign gain_s     = signed'({1'b0, gain_r});
  assign push_valid = (state_r == F_PUSH);
  assign push_data  = '{yaw: yaw_nxt, pitch: pitch_nxt};

  always_comb begin
    yaw_nxt   = yaw_r - prod_x_r[ANGLE_W-1:0];
    pitch_sum = {{(29 - ANGLE_W){pitch_r[ANGLE_W-1]}}, pitch_r} + prod_y_r;
    if (pitch_sum >= PITCH_MAX) begin
      pitch_nxt = PITCH_MAX[ANGLE_W-1:0];
    end else if (pitch_sum <= PITCH_MIN) begin
      pitch_nxt = PITCH_MIN[ANGLE_W-1:0];
    end else begin
      pitch_nxt = pitch_sum[ANGLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      gain_r  <= GAIN_RESET;
      yaw_r   <= '0;
      pitch_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        gain_r <= cfg_data;
      end
      if (push_valid && push_ready) begin
        yaw_r   <= yaw_nxt;
        pitch_r <= pitch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      dx_r <= in_data.cursor_dx;
      dy_r <= in_data.cursor_dy;
    end
    if (state_r == F_MUL) begin
      prod_x_r <= dx_r * gain_s;
      prod_y_r <= dy_r * gain_s;
    end
  end

  a_pitch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pitch_r <= 24'sh400000) && (pitch_r >= -24'sh400000))
    else $error("pitch left its quarter-turn range");

  a_push_from_push_state: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && push_ready |=> state_r == F_IDLE)
    else $error("front did not return to idle after push");

endmodule
`default_nettype wire

// File: sv/ypvr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module ypvr_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push_valid,
  output logic                         push_ready,
  input  wire ypvr_pkg::ypvr_angles_t  push_data,
  output logic                         pop_valid,
  input  wire logic                    pop_ready,
  output ypvr_pkg::ypvr_angles_t       pop_data
);
  import ypvr_pkg::*;

  localparam logic [QPTR_W:0] FULL_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

  ypvr_angles_t      mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != FULL_COUNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// File: sv/ypvr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ypvr_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    pop_valid,
  output logic                         pop_ready,
  input  wire ypvr_pkg::ypvr_angles_t  pop_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output ypvr_pkg::ypvr_out_t          out_data
);
  import ypvr_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_LOOK = 2'd1;
  localparam logic [1:0] B_MUL  = 2'd2;
  localparam logic [1:0] B_EMIT = 2'd3;

  localparam logic [2:0] MUL_DONE = 3'd4;

  localparam logic [2:0] VEC_NORMAL = 3'd0;
  localparam logic [2:0] VEC_VIEW   = 3'd1;
  localparam logic [2:0] VEC_LB     = 3'd2;
  localparam logic [2:0] VEC_LT     = 3'd3;
  localparam logic [2:0] VEC_RT     = 3'd4;
  localparam logic [2:0] VEC_RB     = 3'd5;

  localparam logic [1:0] C_ZERO = 2'd0;
  localparam logic [1:0] C_POS  = 2'd1;
  localparam logic [1:0] C_NEG  = 2'd2;
  localparam logic [1:0] C_TWO  = 2'd3;

  localparam int ACC_W      = (SIN_W + 3 > 17) ? SIN_W + 3 : 17;
  localparam int MUL_W      = 2 * SIN_W;
  localparam int IDX_PROD_W = ANGLE_W + IDX_W + 1;

  localparam logic signed [MUL_W-1:0] MUL_BIAS = MUL_W'(1) << (COORD_FRACTION_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-32768);

  function automatic logic [IDX_W-1:0] angle_index(input logic [ANGLE_W-1:0] a);
    logic [IDX_PROD_W-1:0] p;
    p = IDX_PROD_W'(a) * IDX_PROD_W'(SINE_TABLE_ENTRIES);
    return p[ANGLE_W +: IDX_W];
  endfunction

  function automatic logic signed [ACC_W-1:0] term(input logic signed [SIN_W-1:0] e,
                                                   input logic [1:0] c);
    logic signed [ACC_W-1:0] ex;
    ex = ACC_W'(e);
    case (c)
      C_POS:   return ex;
      C_NEG:   return -ex;
      C_TWO:   return ex <<< 1;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > SAT_HI) begin
      return 16'sh7FFF;
    end else if (v < SAT_LO) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  logic [1:0]              state_r, state_nxt;
  logic [2:0]              step_r, step_nxt;
  logic [2:0]              vec_r, vec_nxt;
  logic [IDX_W-1:0]        ia_r, ica_r, ib_r, icb_r;
  logic signed [SIN_W-1:0] sa_r, ca_r, sb_r, cb_r;
  logic signed [MUL_W-1:0] mul_r;
  logic signed [SIN_W-1:0] pr_r [4];
  logic signed [SIN_W-1:0] op_a, op_b, pr_round;
  logic [1:0]              cx, cy, cz;
  logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;
  logic                    out_valid_r;
  ypvr_out_t               out_data_r, out_nxt;
  logic                    out_free, out_load;

  assign pop_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == B_EMIT) && out_free;

  // products in order: sa*sb, sa*cb, ca*sb, ca*cb
  assign op_a     = step_r[1] ? ca_r : sa_r;
  assign op_b     = step_r[0] ? cb_r : sb_r;
  assign pr_round = SIN_W'((mul_r + MUL_BIAS) >>> COORD_FRACTION_BITS);

  always_comb begin
    case (vec_r)
      VEC_NORMAL: begin cx = C_POS;  cy = C_ZERO; cz = C_ZERO; end
      VEC_VIEW:   begin cx = C_ZERO; cy = C_ZERO; cz = C_TWO;  end
      VEC_LB:     begin cx = C_NEG;  cy = C_NEG;  cz = C_TWO;  end
      VEC_LT:     begin cx = C_NEG;  cy = C_POS;  cz = C_TWO;  end
      VEC_RT:     begin cx = C_POS;  cy = C_POS;  cz = C_TWO;  end
      VEC_RB:     begin cx = C_POS;  cy = C_NEG;  cz = C_TWO;  end
      default:    begin cx = C_ZERO; cy = C_ZERO; cz = C_ZERO; end
    endcase
  end

  // rows of Ry(yaw) * Rx(pitch)
  always_comb begin
    acc_x = term(ca_r, cx) - term(pr_r[0], cy) - term(pr_r[1], cz);
    acc_y = term(cb_r, cy) - term(sb_r, cz);
    acc_z = term(sa_r, cx) + term(pr_r[2], cy) + term(pr_r[3], cz);
    out_nxt.vector_index = vec_r;
    out_nxt.coord_x      = sat16(acc_x);
    out_nxt.coord_y      = sat16(acc_y);
    out_nxt.coord_z      = sat16(acc_z);
    out_nxt.last         = (vec_r == VEC_RB);
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    vec_nxt   = vec_r;
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          state_nxt = B_LOOK;
        end
      end
      B_LOOK: begin
        state_nxt = B_MUL;
        step_nxt  = '0;
      end
      B_MUL: begin
        step_nxt = step_r + 3'd1;
        if (step_r == MUL_DONE) begin
          state_nxt = B_EMIT;
          vec_nxt   = VEC_NORMAL;
        end
      end
      B_EMIT: begin
        if (out_load) begin
          vec_nxt = vec_r + 3'd1;
          if (vec_r == VEC_RB) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      vec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      vec_r   <= vec_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      ia_r  <= angle_index(pop_data.yaw);
      ica_r <= angle_index(pop_data.yaw + QUARTER_TURN);
      ib_r  <= angle_index(pop_data.pitch);
      icb_r <= angle_index(pop_data.pitch + QUARTER_TURN);
    end
    if (state_r == B_LOOK) begin
      sa_r <= SINE_TAB[ia_r];
      ca_r <= SINE_TAB[ica_r];
      sb_r <= SINE_TAB[ib_r];
      cb_r <= SINE_TAB[icb_r];
    end
    if (state_r == B_MUL) begin
      if (step_r != MUL_DONE) begin
        mul_r <= op_a * op_b;
      end
      if (step_r != 3'd0) begin
        pr_r[2'(step_r - 3'd1)] <= pr_round;
      end
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  a_vec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EMIT |-> vec_r <= VEC_RB)
    else $error("vector counter out of range");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_MUL |-> step_r <= MUL_DONE)
    else $error("multiply step out of range");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && vec_r == VEC_RB |=> state_r == B_IDLE && out_data_r.last)
    else $error("final vector did not close the update");

endmodule
`default_nettype wire

// File: sv/yaw_pitch_view_rotator.sv
// The back end works on one update at a time (pop, table lookup,
//   four products on one shared multiplier, six result beats) and pops again only when idle.
// The front end takes a new item only when idle, once its last one is in the 2-entry queue.
// Reset (rst_n low, synchronous): angles zero, mouse_gain 400, queue empty, no result.
`timescale 1ns / 1ps
`default_nettype none
module yaw_pitch_view_rotator (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ypvr_pkg::ypvr_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ypvr_pkg::ypvr_out_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [15:0]         cfg_data
);
  import ypvr_pkg::*;

  logic         push_valid, push_ready;
  ypvr_angles_t push_data;
  logic         pop_valid, pop_ready;
  ypvr_angles_t pop_data;

  assign cfg_ready = 1'b1;

  ypvr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ypvr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ypvr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int FB        = ypvr_pkg::COORD_FRACTION_BITS;
  localparam int N_ENT     = ypvr_pkg::SINE_TABLE_ENTRIES;
  localparam int N_VEC     = 6;
  localparam int N_DIR     = 18;
  localparam int N_PHASE   = 8;
  localparam int PHASE_LEN = 25;
  localparam int CYCLE_CAP = 600000;
  localparam int TAIL      = 30;
  localparam bit [63:0] PI_SCALED = 64'd3373259426;
  localparam bit [23:0] QTR_TURN  = 24'h400000;
  localparam longint    PITCH_LIM = 64'sd4194304;

  typedef enum bit [1:0] {
    VIEW_FREE     = 2'd0,
    VIEW_RESET    = 2'd1,
    VIEW_TILT_UP  = 2'd2,
    VIEW_TILT_DN  = 2'd3
  } view_pick_t;

  typedef struct packed {
    bit         load_gain;
    bit [15:0]  gain;
    bit [11:0]  dx;
    bit [11:0]  dy;
    view_pick_t typed_sel;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  ypvr_pkg::ypvr_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  ypvr_pkg::ypvr_out_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [15:0]         cfg_data;

  yaw_pitch_view_rotator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // view state tracked alongside the block
  bit [15:0] gain_st;
  bit [23:0] yaw_st;
  longint    pitch_st;
  longint    sin_lut [N_ENT];
  int        basis_x [N_VEC] = '{1, 0, -1, -1, 1, 1};
  int        basis_y [N_VEC] = '{0, 0, -1, 1, 1, -1};
  int        basis_z [N_VEC] = '{0, 2, 2, 2, 2, 2};

  ypvr_pkg::ypvr_out_t rotated_vec_q [$];
  ypvr_pkg::ypvr_out_t view_vecs [N_VEC];
  ypvr_pkg::ypvr_out_t typed_vecs [3*N_VEC];
  plan_row_t           dir_plan [N_DIR];

  int mismatch_cnt;
  int cycle_cnt;
  bit no_idle;
  int stall_run;

  // sine over a quarter turn, r in 2^-30 quarter turns, result in QF
  function automatic longint taylor_sin(bit [63:0] r);
    bit [63:0] x;
    bit [63:0] x2;
    bit [63:0] term;
    bit [63:0] div;
    longint    acc;
    longint    v;
    int        n;
    x    = (r * PI_SCALED) >> 31;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      div  = 64'((2 * n) * (2 * n + 1));
      term = term / div;
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (acc + (longint'(1) << (29 - FB))) >>> (30 - FB);
    if (v > (longint'(1) << FB)) begin
      v = longint'(1) << FB;
    end
    return v;
  endfunction

  function automatic longint lut_at(bit [23:0] a);
    bit [63:0] idx;
    idx = (64'(a) * N_ENT) >> 24;
    return sin_lut[idx];
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (longint'(1) << (FB - 1))) >>> FB;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  function automatic ypvr_pkg::ypvr_out_t mk_vec(int idx, int x, int y, int z);
    ypvr_pkg::ypvr_out_t v;
    v.vector_index = 3'(idx);
    v.coord_x      = 16'(x);
    v.coord_y      = 16'(y);
    v.coord_z      = 16'(z);
    v.last         = (idx == N_VEC - 1);
    return v;
  endfunction

  function automatic plan_row_t mk_row(bit ld, int g, int dx, int dy, view_pick_t sel);
    plan_row_t row;
    row.load_gain = ld;
    row.gain      = 16'(g);
    row.dx        = 12'(dx);
    row.dy        = 12'(dy);
    row.typed_sel = sel;
    return row;
  endfunction

  function automatic bit [11:0] rand_offset();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 12'($urandom);
      5, 6, 7:       return 12'(int'($urandom_range(0, 32)) - 16);
      8: begin
        case ($urandom_range(0, 3))
          0:       return 12'h800;
          1:       return 12'h7FF;
          2:       return 12'h000;
          default: return 12'hFFF;
        endcase
      end
      default:       return 12'h000;
    endcase
  endfunction

  function automatic bit [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'd400;
      4:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 2000));
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // angle update, matrix Ry(yaw) * Rx(pitch), six rotated basis vectors
  task automatic advance_view(input ypvr_pkg::ypvr_in_t beat);
    longint    dxs;
    longint    dys;
    longint    p;
    longint    sa;
    longint    ca;
    longint    sb;
    longint    cb;
    longint    m [9];
    longint    acc [3];
    bit [23:0] pa;
    int        k;
    int        r;
    dxs    = beat.cursor_dx;
    dys    = beat.cursor_dy;
    yaw_st = 24'(longint'(yaw_st) - dxs * longint'(gain_st));
    p      = pitch_st + dys * longint'(gain_st);
    if (p >= PITCH_LIM) begin
      p = PITCH_LIM;
    end
    if (p <= -PITCH_LIM) begin
      p = -PITCH_LIM;
    end
    pitch_st = p;
    pa = 24'(pitch_st);
    sa = lut_at(yaw_st);
    ca = lut_at(yaw_st + QTR_TURN);
    sb = lut_at(pa);
    cb = lut_at(pa + QTR_TURN);
    m[0] = ca; m[1] = -qmul(sa, sb); m[2] = -qmul(sa, cb);
    m[3] = 0;  m[4] = cb;            m[5] = -sb;
    m[6] = sa; m[7] = qmul(ca, sb);  m[8] = qmul(ca, cb);
    for (k = 0; k < N_VEC; k++) begin
      for (r = 0; r < 3; r++) begin
        acc[r] = m[3*r] * basis_x[k] + m[3*r+1] * basis_y[k] + m[3*r+2] * basis_z[k];
      end
      view_vecs[k].vector_index = 3'(k);
      view_vecs[k].coord_x      = clip16(acc[0]);
      view_vecs[k].coord_y      = clip16(acc[1]);
      view_vecs[k].coord_z      = clip16(acc[2]);
      view_vecs[k].last         = (k == N_VEC - 1);
    end
  endtask

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input ypvr_pkg::ypvr_in_t beat, input view_pick_t sel);
    int k;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    advance_view(beat);
    for (k = 0; k < N_VEC; k++) begin
      if (sel == VIEW_FREE) begin
        rotated_vec_q.push_back(view_vecs[k]);
      end else begin
        rotated_vec_q.push_back(typed_vecs[(int'(sel) - 1) * N_VEC + k]);
      end
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (rotated_vec_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_gain(input bit [15:0] g);
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    gain_st = g;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic idle_sender();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic check_vec(input ypvr_pkg::ypvr_out_t got);
    ypvr_pkg::ypvr_out_t want;
    bit                  bad;
    if (rotated_vec_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 40) begin
        $display("%0t: beat with nothing expected, actual idx %0d x %0d y %0d z %0d last %0b",
                 $time, got.vector_index, got.coord_x, got.coord_y, got.coord_z, got.last);
      end
    end else begin
      want = rotated_vec_q.pop_front();
      bad  = (got.vector_index !== want.vector_index) || (got.coord_x !== want.coord_x) ||
             (got.coord_y !== want.coord_y) || (got.coord_z !== want.coord_z) ||
             (got.last !== want.last);
      if (bad) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 40) begin
          $display("%0t: expected idx %0d x %0d y %0d z %0d last %0b", $time,
                   want.vector_index, want.coord_x, want.coord_y, want.coord_z, want.last);
          $display("%0t: actual   idx %0d x %0d y %0d z %0d last %0b", $time,
                   got.vector_index, got.coord_x, got.coord_y, got.coord_z, got.last);
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("yaw_pitch_view_rotator verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_vec(out_data);
    end
  end

  // result side back-pressure
  initial begin
    int r;
    out_stall <= 1'b0;
    stall_run = 0;
    forever begin
      @(negedge clk);
      if (stall_run > 0) begin
        stall_run--;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
        end else if (r < 88) begin
          out_stall <= 1'b1;
          stall_run = $urandom_range(0, 2);
        end else if (r < 97) begin
          out_stall <= 1'b1;
          stall_run = $urandom_range(3, 9);
        end else begin
          out_stall <= 1'b1;
          stall_run = $urandom_range(20, 60);
        end
      end
    end
  end

  initial begin
    ypvr_pkg::ypvr_in_t beat;
    bit [63:0]          t;
    bit [63:0]          rem;
    longint             mag;
    int                 k;
    int                 i;
    int                 ph;
    int                 j;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    no_idle   = 1'b0;
    gain_st   = 16'd400;
    yaw_st    = '0;
    pitch_st  = 0;

    for (k = 0; k < N_ENT; k++) begin
      t   = (64'(k) << 32) / N_ENT;
      rem = t & 64'h3FFF_FFFF;
      mag = t[30] ? taylor_sin((64'd1 << 30) - rem) : taylor_sin(rem);
      sin_lut[k] = t[31] ? -mag : mag;
    end

    // level view, straight up, straight down (yaw still zero)
    for (k = 0; k < N_VEC; k++) begin
      typed_vecs[k] = mk_vec(k, 4096 * basis_x[k], 4096 * basis_y[k], 4096 * basis_z[k]);
      typed_vecs[N_VEC + k] = mk_vec(k, 4096 * basis_x[k], -4096 * basis_z[k],
                                     4096 * basis_y[k]);
      typed_vecs[2*N_VEC + k] = mk_vec(k, 4096 * basis_x[k], 4096 * basis_z[k],
                                       -4096 * basis_y[k]);
    end

    dir_plan[0]  = mk_row(1'b0, 0,     0,     0,     VIEW_RESET);
    dir_plan[1]  = mk_row(1'b1, 65535, 0,     2047,  VIEW_TILT_UP);
    dir_plan[2]  = mk_row(1'b0, 0,     0,     -2048, VIEW_TILT_DN);
    dir_plan[3]  = mk_row(1'b0, 0,     -2048, 0,     VIEW_FREE);
    dir_plan[4]  = mk_row(1'b0, 0,     2047,  2047,  VIEW_FREE);
    dir_plan[5]  = mk_row(1'b1, 1,     1,     1,     VIEW_FREE);
    dir_plan[6]  = mk_row(1'b0, 0,     -1,    -1,    VIEW_FREE);
    dir_plan[7]  = mk_row(1'b1, 0,     -2048, 2047,  VIEW_FREE);
    dir_plan[8]  = mk_row(1'b1, 400,   0,     0,     VIEW_FREE);
    dir_plan[9]  = mk_row(1'b0, 0,     1365,  -1366, VIEW_FREE);
    dir_plan[10] = mk_row(1'b0, 0,     -1366, 1365,  VIEW_FREE);
    dir_plan[11] = mk_row(1'b1, 16384, 256,   0,     VIEW_FREE);
    dir_plan[12] = mk_row(1'b0, 0,     256,   256,   VIEW_FREE);
    dir_plan[13] = mk_row(1'b0, 0,     512,   -512,  VIEW_FREE);
    dir_plan[14] = mk_row(1'b1, 32768, -1,    -1,    VIEW_FREE);
    dir_plan[15] = mk_row(1'b1, 21845, 2047,  -2048, VIEW_FREE);
    dir_plan[16] = mk_row(1'b1, 43690, -2048, 2047,  VIEW_FREE);
    dir_plan[17] = mk_row(1'b0, 0,     -1,    1,     VIEW_FREE);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      if (dir_plan[i].load_gain) begin
        drain_results();
        write_gain(dir_plan[i].gain);
      end
      beat.cursor_dx = dir_plan[i].dx;
      beat.cursor_dy = dir_plan[i].dy;
      send_beat(beat, dir_plan[i].typed_sel);
      idle_sender();
    end

    for (ph = 0; ph < N_PHASE; ph++) begin
      drain_results();
      write_gain(pick_gain());
      no_idle = (ph % 4 == 2);
      for (j = 0; j < PHASE_LEN; j++) begin
        beat.cursor_dx = rand_offset();
        beat.cursor_dy = rand_offset();
        send_beat(beat, VIEW_FREE);
        if ($urandom_range(0, 39) == 0) begin
          drain_results();
        end else begin
          idle_sender();
        end
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (TAIL) @(posedge clk);
    if (mismatch_cnt == 0 && rotated_vec_q.size() == 0) begin
      $display("yaw_pitch_view_rotator verification clean");
    end else begin
      $display("yaw_pitch_view_rotator verification failed");
    end
    $finish;
  end

endmodule
